// ===== rtl/running_median_two_heaps_defines.svh =====
// Assertion macros shared by the checker.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define RMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define RMH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/rmh_pkg.sv =====
package rmh_pkg;
  localparam int unsigned MaxSamplesDef = 1024;
  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 11;

  // Datapath commands.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_START,     // latch sample, restart, size bookkeeping
    CMD_UP_RD,     // read parent during sift-up
    CMD_UP_STEP,   // compare with parent, swap or stop
    CMD_ROOTS,     // compare the two roots
    CMD_DN_RD,     // read children during sift-down
    CMD_DN_STEP,   // pick best child, swap or stop
    CMD_FINISH     // register result word
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic sel_upper;  // heap that the sift operates on
  } rmh_ctl_t;

  typedef struct packed {
    logic full;       // store full, reject
    logic sel_upper;  // heap that took the insert
    logic up_done;    // sift-up finished
    logic swap_roots; // roots must exchange
    logic dn_done;    // sift-down finished
  } rmh_sts_t;
endpackage

// ===== rtl/rmh_datapath.sv =====
module rmh_datapath import rmh_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DataW-1:0]  sample_i,
  input  logic              restart_i,
  input  rmh_ctl_t          ctl_i,
  output rmh_sts_t          sts_o,
  output logic [DataW-1:0]  median_o,
  output logic [CountW-1:0] sample_count_o,
  output logic              overflow_o
);
  localparam int unsigned LoDepth = (MaxSamples + 1) / 2;
  localparam int unsigned UpDepth = (MaxSamples / 2 > 0) ? MaxSamples / 2 : 1;
  localparam int unsigned AW = $clog2(LoDepth + 1) + 1;
  localparam int unsigned TW = $clog2(MaxSamples + 1);
  localparam int unsigned LIW = (LoDepth > 1) ? $clog2(LoDepth) : 1;
  localparam int unsigned UIW = (UpDepth > 1) ? $clog2(UpDepth) : 1;

  logic [DataW-1:0] lo_mem [LoDepth];
  logic [DataW-1:0] up_mem [UpDepth];

  logic [AW-1:0] lo_size_q, up_size_q;
  logic [AW-1:0] idx_q;
  logic [DataW-1:0] cur_q, lo_root_q, up_root_q, rd_a_q, rd_b_q;
  logic full_q, swap_q, sel_q;
  logic [DataW-1:0] carry_q; // value of the old lower root for second sift

  logic [AW-1:0] size_sel, par_idx, lch, rch;
  assign size_sel = ctl_i.sel_upper ? up_size_q : lo_size_q;
  assign par_idx  = (idx_q - AW'(1)) >> 1;
  assign lch      = (idx_q << 1) + AW'(1);
  assign rch      = (idx_q << 1) + AW'(2);

  // Sizes seen by a new word, after an optional restart.
  logic [AW-1:0] ls, us;
  logic [TW-1:0] start_fill;
  assign ls = restart_i ? '0 : lo_size_q;
  assign us = restart_i ? '0 : up_size_q;
  assign start_fill = TW'(ls) + TW'(us);

  function automatic logic above(input logic is_max, input logic [DataW-1:0] x,
                                 input logic [DataW-1:0] y);
    above = is_max ? (x > y) : (x < y);
  endfunction

  logic is_max;
  assign is_max = !ctl_i.sel_upper;

  // Memory write: one port per heap, address from idx_q, data chosen per command.
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [DataW-1:0] wr_data;
  logic l_ok, r_ok;
  logic [AW-1:0] best;
  logic [DataW-1:0] best_v;

  always_comb begin
    l_ok = lch < size_sel;
    r_ok = rch < size_sel;
    best = idx_q;
    best_v = cur_q;
    if (l_ok && above(is_max, rd_a_q, best_v)) begin
      best = lch;
      best_v = rd_a_q;
    end
    if (r_ok && above(is_max, rd_b_q, best_v)) begin
      best = rch;
      best_v = rd_b_q;
    end
  end

  // Sift moves the hole: cur_q rides along, the displaced entry is written back.
  logic up_swap;
  assign up_swap = (idx_q != '0) && above(is_max, cur_q, rd_a_q);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx_q;
    wr_data = cur_q;
    unique case (ctl_i.cmd)
      CMD_UP_STEP: begin
        wr_en = 1'b1;
        wr_data = up_swap ? rd_a_q : cur_q;
      end
      CMD_DN_STEP: begin
        wr_en = 1'b1;
        wr_data = best_v;
      end
      default: ;
    endcase
  end

  // One write per step: the entry that moves, or the settled value.
  always_ff @(posedge clk_i) begin
    if (wr_en && !ctl_i.sel_upper) lo_mem[wr_addr[LIW-1:0]] <= wr_data;
    if (wr_en && ctl_i.sel_upper)  up_mem[wr_addr[UIW-1:0]] <= wr_data;
  end

  logic [AW-1:0] rd_a_addr, rd_b_addr;
  assign rd_a_addr = (ctl_i.cmd == CMD_DN_RD) ? lch : par_idx;
  assign rd_b_addr = rch;

  always_ff @(posedge clk_i) begin
    if (ctl_i.sel_upper) begin
      rd_a_q <= up_mem[rd_a_addr[UIW-1:0]];
      rd_b_q <= up_mem[rd_b_addr[UIW-1:0]];
    end else begin
      rd_a_q <= lo_mem[rd_a_addr[LIW-1:0]];
      rd_b_q <= lo_mem[rd_b_addr[LIW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_size_q <= '0;
      up_size_q <= '0;
      idx_q <= '0;
      cur_q <= '0;
      carry_q <= '0;
      lo_root_q <= '0;
      up_root_q <= '0;
      full_q <= 1'b0;
      swap_q <= 1'b0;
      sel_q <= 1'b0;
      overflow_o <= 1'b0;
      sample_count_o <= '0;
      median_o <= '0;
    end else begin
      unique case (ctl_i.cmd)
        CMD_START: begin
          full_q <= start_fill >= TW'(MaxSamples);
          cur_q <= sample_i;
          if (start_fill >= TW'(MaxSamples)) begin
            lo_size_q <= ls;
            up_size_q <= us;
          end else if (ls == us) begin
            idx_q <= ls;
            lo_size_q <= ls + AW'(1);
            up_size_q <= us;
            sel_q <= 1'b0;
          end else begin
            idx_q <= us;
            up_size_q <= us + AW'(1);
            lo_size_q <= ls;
            sel_q <= 1'b1;
          end
        end
        CMD_UP_STEP: begin
          if (up_swap) idx_q <= par_idx;
          // root changes only when the sample settles at the top
          if ((up_swap && par_idx == '0) || (!up_swap && idx_q == '0)) begin
            if (ctl_i.sel_upper) up_root_q <= cur_q;
            else lo_root_q <= cur_q;
          end
        end
        CMD_ROOTS: begin
          swap_q <= (up_size_q != '0) && (up_root_q < lo_root_q);
          if ((up_size_q != '0) && (up_root_q < lo_root_q)) begin
            cur_q <= up_root_q;
            carry_q <= lo_root_q;
            lo_root_q <= up_root_q;
            up_root_q <= lo_root_q;
            idx_q <= '0;
          end
        end
        CMD_DN_STEP: begin
          if (best != idx_q) begin
            idx_q <= best;
          end else if (!ctl_i.sel_upper) begin
            cur_q <= carry_q;
            idx_q <= '0;
          end
          if (best == idx_q && idx_q == '0) begin
            if (!ctl_i.sel_upper) lo_root_q <= cur_q;
            else up_root_q <= cur_q;
          end else if (idx_q == '0) begin
            if (!ctl_i.sel_upper) lo_root_q <= best_v;
            else up_root_q <= best_v;
          end
        end
        CMD_FINISH: begin
          overflow_o <= full_q;
          sample_count_o <= CountW'(TW'(lo_size_q) + TW'(up_size_q));
          median_o <= (lo_size_q != '0) ? lo_root_q : '0;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.full       = full_q;
  assign sts_o.sel_upper  = sel_q;
  assign sts_o.up_done    = !up_swap;
  assign sts_o.swap_roots = swap_q;
  assign sts_o.dn_done    = (best == idx_q);
endmodule

// ===== rtl/rmh_ctrl.sv =====
module rmh_ctrl import rmh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  rmh_sts_t sts_i,
  output rmh_ctl_t ctl_o
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_URD   = 9'b000000100,
    S_UST   = 9'b000001000,
    S_ROOT  = 9'b000010000,
    S_DRD   = 9'b000100000,
    S_DST   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic upper_q, upper_d;
  logic ovalid_q, ovalid_d;

  assign in_stall_o  = (state_q != S_IDLE) || ovalid_q;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    upper_d = upper_q;
    ovalid_d = ovalid_q && out_stall_i;
    ctl_o.cmd = CMD_NONE;
    ctl_o.sel_upper = upper_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i && !in_stall_o) begin
        ctl_o.cmd = CMD_START;
        state_d = S_START;
      end
      S_START: begin
        upper_d = sts_i.sel_upper;
        state_d = sts_i.full ? S_FIN : S_URD;
      end
      S_URD: begin
        ctl_o.cmd = CMD_UP_RD;
        state_d = S_UST;
      end
      S_UST: begin
        ctl_o.cmd = CMD_UP_STEP;
        state_d = sts_i.up_done ? S_ROOT : S_URD;
      end
      S_ROOT: begin
        ctl_o.cmd = CMD_ROOTS;
        upper_d = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: state_d = sts_i.swap_roots ? S_DRD : S_FIN;
      S_DRD: begin
        ctl_o.cmd = CMD_DN_RD;
        state_d = S_DST;
      end
      S_DST: begin
        ctl_o.cmd = CMD_DN_STEP;
        if (sts_i.dn_done) begin
          if (upper_q) state_d = S_FIN;
          else begin
            upper_d = 1'b1;
            state_d = S_DRD;
          end
        end else state_d = S_DRD;
      end
      S_FIN: begin
        ctl_o.cmd = CMD_FINISH;
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      upper_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      upper_q <= upper_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule

// ===== rtl/running_median_two_heaps.sv =====
// Running median over a stream of unsigned 32-bit samples.
// Input channel: sample_i, restart_i with in_valid_i / in_stall_o. A word is
// taken when valid is high and stall low. restart_i empties the store first.
// Output channel: median_o, sample_count_o, overflow_o with out_valid_o /
// out_stall_i; one result word per input word, in order.
// Samples live in two heap memories (max-heap lower half, min-heap upper
// half). After the accepting edge: a setup step, a parent read and a step per
// sift-up level visited, the root compare, a child read and a step per
// sift-down level visited in each heap when the roots exchange, then the
// result is registered. A rejected sample skips the sifts and the root
// compare. The next word can be taken in the cycle after the result is.
// One item is in flight at a time; the result register holds a finished
// word while the receiver stalls, and the input stays stalled until it is
// taken.
// The full store rejects a sample with overflow_o set, median unchanged.
// Reset clears the sizes, roots and result registers; heap memories need no clearing pass.
module running_median_two_heaps import rmh_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DataW-1:0]  sample_i,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DataW-1:0]  median_o,
  output logic [CountW-1:0] sample_count_o,
  output logic              overflow_o
);
  rmh_ctl_t ctl;
  rmh_sts_t sts;

  rmh_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  rmh_datapath #(.MaxSamples(MaxSamples)) u_dp (
    .clk_i, .rst_ni, .sample_i, .restart_i, .ctl_i(ctl), .sts_o(sts),
    .median_o, .sample_count_o, .overflow_o
  );
endmodule

// ===== rtl/rmh_checker.sv =====
module rmh_checker import rmh_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CountW-1:0] sample_count_o,
  input logic              overflow_o
);
`include "running_median_two_heaps_defines.svh"
  `RMH_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `RMH_ASSERT(a_busy, out_valid_o |-> in_stall_o, "input taken while result waits")
  `RMH_ASSERT(a_ovf_cnt, out_valid_o && overflow_o |-> sample_count_o != '0, "overflow on empty")
  `RMH_ASSERT_ALWAYS(a_rst, !rst_ni |-> !out_valid_o, "valid in reset")
endmodule

bind running_median_two_heaps rmh_checker u_chk (.*);
